### sv/lsts_pkg.sv
// ----------------------------------------------------------------------------
// Line-scan track steering: shared package
// Frame geometry, steering constants, register and class codes, and the
// record types that pass between the pixel scanner and the drive stage.
// ----------------------------------------------------------------------------
package lsts_pkg;

  // Frame geometry
  localparam int PIXELS = 128;
  localparam int IDX_W  = $clog2(PIXELS);
  localparam int POS_W  = 7;
  localparam int PIX_W  = 8;
  localparam int SPD_W  = 16;
  localparam int DUTY_W = 8;
  localparam int SERVO_W = 9;

  // Gradient window and steering constants
  localparam int GRAD_LO    = 20;
  localparam int GRAD_HI    = 107;
  localparam int HARD_RIGHT = 110;
  localparam int HARD_LEFT  = 20;
  localparam int ANGLE_BASE = 48;
  localparam int CENTRE_REF = 62;
  localparam int LOST_STEP  = 15;
  localparam int SERVO_MUL  = 177;
  localparam int SERVO_ADD  = 195;
  localparam int ANGLE_MIN  = 12;
  localparam int ANGLE_MAX  = 85;

  // x*177/100 as a multiply by a scaled reciprocal of 100
  localparam int SERVO_SHIFT   = 19;
  localparam int SERVO_RECIP   = SERVO_MUL * ((2**SERVO_SHIFT + 99) / 100);
  localparam int SERVO_RECIP_W = $clog2(SERVO_RECIP + 1);

  // Duty fractions as scaled reciprocals
  localparam int TENTH_SHIFT = 16;
  localparam int TENTH_RECIP = (2**TENTH_SHIFT + 9) / 10;
  localparam int NINE_TENTHS = 9 * TENTH_RECIP;
  localparam int SEVEN_TENTHS = 7 * TENTH_RECIP;
  localparam int THIRD_SHIFT = 9;
  localparam int THIRD_RECIP = (2**THIRD_SHIFT + 2) / 3;

  // Frame record queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LEFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY = 3'd4;

  // Steering classes
  localparam logic [1:0] CLS_LOST   = 2'd0;
  localparam logic [1:0] CLS_RIGHT  = 2'd1;
  localparam logic [1:0] CLS_LEFT   = 2'd2;
  localparam logic [1:0] CLS_CENTRE = 2'd3;

  // Edge summary of one frame
  typedef struct packed {
    logic             rise_seen;
    logic             fall_seen;
    logic [POS_W-1:0] rise_first;
    logic [POS_W-1:0] rise_last;
    logic [POS_W-1:0] fall_first;
    logic [POS_W-1:0] fall_last;
    logic [SPD_W-1:0] speed;
  } lsts_frame_t;

  // Settings used by the drive stage
  typedef struct packed {
    logic [SPD_W-1:0]  speed_threshold;
    logic [POS_W-1:0]  band_left;
    logic [POS_W-1:0]  band_right;
    logic [DUTY_W-1:0] base_duty;
    logic [DUTY_W-1:0] fast_hi;
    logic [DUTY_W-1:0] fast_lo;
    logic [DUTY_W-1:0] slow_hi;
    logic [DUTY_W-1:0] slow_lo;
  } lsts_drive_cfg_t;

endpackage

### sv/lsts_scan.sv
// ----------------------------------------------------------------------------
// Line-scan track steering: pixel scanner
// Takes one pixel per transfer, forms the halved gradient over the edge
// window and tracks the first and last rising and falling edges. The
// frame's last pixel pushes the edge summary into the frame queue.
// ----------------------------------------------------------------------------
module lsts_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lsts_pkg::PIX_W-1:0]   pixel_value,
  input  logic                         frame_end,
  input  logic [lsts_pkg::SPD_W-1:0]   speed_measure,
  input  logic [lsts_pkg::POS_W-1:0]   slope_threshold,
  input  logic                         q_full,
  output logic                         push,
  output lsts_pkg::lsts_frame_t        frame
);
  import lsts_pkg::*;

  logic [PIX_W-1:0] pixel_delay [2];
  logic [IDX_W-1:0] pixel_index;
  logic             rise_seen;
  logic             fall_seen;
  logic [POS_W-1:0] rise_first;
  logic [POS_W-1:0] rise_last;
  logic [POS_W-1:0] fall_first;
  logic [POS_W-1:0] fall_last;

  logic             rise_seen_next;
  logic             fall_seen_next;
  logic [POS_W-1:0] rise_first_next;
  logic [POS_W-1:0] rise_last_next;
  logic [POS_W-1:0] fall_first_next;
  logic [POS_W-1:0] fall_last_next;

  logic              take;
  logic              grad_on;
  logic [POS_W-1:0]  pos;
  logic signed [8:0] diff;
  logic signed [8:0] grad;
  logic signed [8:0] thr;
  logic signed [8:0] fall_lim;
  logic              is_rise;
  logic              is_fall;

  // Stall only a frame end that finds the queue full
  assign in_ready = !(frame_end && q_full);
  assign take     = in_valid && in_ready;

  // Gradient of the pixel one behind the incoming one
  assign grad_on  = (pixel_index >= IDX_W'(GRAD_LO + 1)) &&
                    (pixel_index <= IDX_W'(GRAD_HI + 1));
  assign pos      = POS_W'(pixel_index - IDX_W'(1));
  assign diff     = $signed({1'b0, pixel_value}) - $signed({1'b0, pixel_delay[1]});
  assign grad     = diff >>> 1;
  assign thr      = $signed({2'b00, slope_threshold});
  assign fall_lim = -thr - 9'sd1;
  assign is_rise  = grad_on && (grad > thr);
  assign is_fall  = grad_on && !(grad > thr) && rise_seen && (grad < fall_lim);

  // Edge bookkeeping including the current pixel
  always_comb begin
    rise_seen_next  = rise_seen;
    fall_seen_next  = fall_seen;
    rise_first_next = rise_first;
    rise_last_next  = rise_last;
    fall_first_next = fall_first;
    fall_last_next  = fall_last;
    if (is_rise) begin
      if (!rise_seen) begin
        rise_seen_next  = 1'b1;
        rise_first_next = pos;
      end
      rise_last_next = pos;
    end else if (is_fall) begin
      if (!fall_seen) begin
        fall_seen_next  = 1'b1;
        fall_first_next = pos;
      end
      fall_last_next = pos;
    end
  end

  // Frame summary handed to the queue
  assign push             = take && frame_end;
  assign frame.rise_seen  = rise_seen_next;
  assign frame.fall_seen  = fall_seen_next;
  assign frame.rise_first = rise_first_next;
  assign frame.rise_last  = rise_last_next;
  assign frame.fall_first = fall_first_next;
  assign frame.fall_last  = fall_last_next;
  assign frame.speed      = speed_measure;

  // Advance the delay line and index; clear edges at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_delay[0] <= '0;
      pixel_delay[1] <= '0;
      pixel_index    <= '0;
      rise_seen      <= 1'b0;
      fall_seen      <= 1'b0;
      rise_first     <= '0;
      rise_last      <= '0;
      fall_first     <= '0;
      fall_last      <= '0;
    end else if (take) begin
      pixel_delay[1] <= pixel_delay[0];
      pixel_delay[0] <= pixel_value;
      if (frame_end) begin
        pixel_index <= '0;
        rise_seen   <= 1'b0;
        fall_seen   <= 1'b0;
        rise_first  <= '0;
        rise_last   <= '0;
        fall_first  <= '0;
        fall_last   <= '0;
      end else begin
        if (pixel_index < IDX_W'(PIXELS - 1)) begin
          pixel_index <= pixel_index + IDX_W'(1);
        end
        rise_seen  <= rise_seen_next;
        fall_seen  <= fall_seen_next;
        rise_first <= rise_first_next;
        rise_last  <= rise_last_next;
        fall_first <= fall_first_next;
        fall_last  <= fall_last_next;
      end
    end
  end

endmodule

### sv/lsts_fifo.sv
// ----------------------------------------------------------------------------
// Line-scan track steering: frame queue
// Short queue of frame summaries between the scanner and the drive stage.
// ----------------------------------------------------------------------------
module lsts_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lsts_pkg::lsts_frame_t push_data,
  input  logic                  pop,
  output lsts_pkg::lsts_frame_t head,
  output logic                  full,
  output logic                  empty
);
  import lsts_pkg::*;

  lsts_frame_t        entry [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

### sv/lsts_drive.sv
// ----------------------------------------------------------------------------
// Line-scan track steering: drive stage
// Turns a frame summary into the track centre, steering class, servo duty
// and motor duties, and keeps the lost-track, turn and angle history.
// Two stages: decision, then servo scaling into the output register.
// ----------------------------------------------------------------------------
module lsts_drive (
  input  logic                          clk,
  input  logic                          rst,
  input  lsts_pkg::lsts_frame_t         head,
  input  logic                          q_empty,
  output logic                          pop,
  input  lsts_pkg::lsts_drive_cfg_t     cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lsts_pkg::POS_W-1:0]    track_centre,
  output logic [1:0]                    steer_class,
  output logic                          servo_update,
  output logic [lsts_pkg::SERVO_W-1:0]  servo_duty,
  output logic [lsts_pkg::DUTY_W-1:0]   motor_a_duty,
  output logic [lsts_pkg::DUTY_W-1:0]   motor_b_duty
);
  import lsts_pkg::*;

  localparam int PROD_W = POS_W + SERVO_RECIP_W;

  // History
  logic              lost_mode;
  logic              turn_right;
  logic [7:0]        last_angle;

  // Decision stage registers
  logic              a_valid;
  logic [POS_W-1:0]  a_centre;
  logic [1:0]        a_cls;
  logic              a_upd;
  logic [POS_W-1:0]  a_angle;
  logic [DUTY_W-1:0] a_ma;
  logic [DUTY_W-1:0] a_mb;

  logic              a_ready;
  logic              b_ready;

  logic [8:0]        sum;
  logic [POS_W-1:0]  m_raw;
  logic [POS_W-1:0]  m_val;
  logic              lost_after;
  logic [1:0]        cls;
  logic              slow;
  logic              right_dir;
  logic signed [9:0] m_s;
  logic signed [9:0] last_s;
  logic signed [9:0] band_s;
  logic signed [9:0] half;
  logic signed [9:0] angle;
  logic [POS_W-1:0]  angle_clamp;
  logic [7:0]        angle_sat;
  logic              upd;
  logic [DUTY_W-1:0] ma;
  logic [DUTY_W-1:0] mb;
  logic              lost_mode_next;
  logic              turn_right_next;
  logic [7:0]        last_angle_next;
  logic [PROD_W-1:0] prod;

  assign b_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || b_ready;
  assign pop     = !q_empty && a_ready;

  // Centre from the edge summary
  assign sum = {2'b00, head.rise_first} + {2'b00, head.rise_last} +
               {2'b00, head.fall_first} + {2'b00, head.fall_last};

  always_comb begin
    if (!head.rise_seen && !head.fall_seen) begin
      m_raw = '0;
    end else if (!head.rise_seen || !head.fall_seen) begin
      m_raw = sum[POS_W:1];
    end else begin
      m_raw = sum[POS_W+1:2];
    end
  end

  // Force a hard turn while the track stays lost
  assign lost_after = lost_mode && (m_raw == '0);
  assign m_val = lost_after ? (turn_right ? POS_W'(HARD_RIGHT) : POS_W'(HARD_LEFT)) : m_raw;

  always_comb begin
    if (m_val == '0) begin
      cls = CLS_LOST;
    end else if (m_val < cfg.band_left) begin
      cls = CLS_LEFT;
    end else if (m_val > cfg.band_right) begin
      cls = CLS_RIGHT;
    end else begin
      cls = CLS_CENTRE;
    end
  end

  assign slow   = head.speed < cfg.speed_threshold;
  assign m_s    = $signed({3'b000, m_val});
  assign last_s = $signed({{2{last_angle[7]}}, last_angle});
  assign band_s = (cls == CLS_RIGHT) ? $signed({3'b000, cfg.band_right})
                                     : $signed({3'b000, cfg.band_left});
  assign half   = ($signed(10'(CENTRE_REF)) - m_s) >>> 1;

  // Angle, servo update and motor direction per class
  always_comb begin
    angle     = '0;
    upd       = 1'b1;
    right_dir = 1'b0;
    unique case (cls)
      CLS_LOST: begin
        right_dir = turn_right;
        upd       = slow;
        angle     = turn_right ? last_s - $signed(10'(LOST_STEP))
                               : last_s + $signed(10'(LOST_STEP));
      end
      CLS_RIGHT, CLS_LEFT: begin
        right_dir = (cls == CLS_RIGHT);
        angle     = $signed(10'(ANGLE_BASE)) + band_s - m_s;
      end
      CLS_CENTRE: begin
        angle = half + $signed(10'(ANGLE_BASE));
      end
      default: begin
        angle = '0;
      end
    endcase
  end

  // Clamp for the servo, saturate for the history
  always_comb begin
    if (angle < $signed(10'(ANGLE_MIN))) begin
      angle_clamp = POS_W'(ANGLE_MIN);
    end else if (angle > $signed(10'(ANGLE_MAX))) begin
      angle_clamp = POS_W'(ANGLE_MAX);
    end else begin
      angle_clamp = angle[POS_W-1:0];
    end
    if (angle > 10'sd127) begin
      angle_sat = 8'h7f;
    end else if (angle < -10'sd128) begin
      angle_sat = 8'h80;
    end else begin
      angle_sat = angle[7:0];
    end
  end

  // Motor duties: base duty when centred, else braking when slow or fast, biased by direction
  always_comb begin
    if (cls == CLS_CENTRE) begin
      ma = cfg.base_duty;
      mb = cfg.base_duty;
    end else if (right_dir) begin
      ma = slow ? cfg.slow_lo : cfg.fast_lo;
      mb = slow ? cfg.slow_hi : cfg.fast_hi;
    end else begin
      ma = slow ? cfg.slow_hi : cfg.fast_hi;
      mb = slow ? cfg.slow_lo : cfg.fast_lo;
    end
  end

  // History update
  always_comb begin
    lost_mode_next  = lost_after;
    turn_right_next = turn_right;
    last_angle_next = last_angle;
    unique case (cls)
      CLS_LOST: begin
        lost_mode_next = 1'b1;
      end
      CLS_RIGHT, CLS_LEFT: begin
        if (!lost_after) begin
          turn_right_next = right_dir;
        end
        last_angle_next = angle_sat;
      end
      CLS_CENTRE: begin
        last_angle_next = last_angle;
      end
      default: begin
        lost_mode_next = lost_after;
      end
    endcase
  end

  // Decision stage and history
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      lost_mode  <= 1'b0;
      turn_right <= 1'b0;
      last_angle <= '0;
    end else begin
      if (a_ready) begin
        a_valid <= !q_empty;
      end
      if (pop) begin
        lost_mode  <= lost_mode_next;
        turn_right <= turn_right_next;
        last_angle <= last_angle_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_centre <= m_val;
      a_cls    <= cls;
      a_upd    <= upd;
      a_angle  <= angle_clamp;
      a_ma     <= ma;
      a_mb     <= mb;
    end
  end

  // Servo scaling: angle*177/100 + 195
  assign prod = PROD_W'(a_angle) * PROD_W'(SERVO_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      track_centre <= a_centre;
      steer_class  <= a_cls;
      servo_update <= a_upd;
      servo_duty   <= a_upd ? SERVO_W'(prod >> SERVO_SHIFT) + SERVO_W'(SERVO_ADD) : '0;
      motor_a_duty <= a_ma;
      motor_b_duty <= a_mb;
    end
  end

endmodule

### sv/line_scan_track_steering.sv
// Throughput: one pixel per cycle while the frame queue has room for each last pixel, frames back to back with no gap.
// The result of a frame is registered in turn in the frame queue, the decision stage and,
// after servo scaling, the output register.
// A full frame queue stalls only a last pixel; a stalled result leaves pixels flowing.
// Reset (rst, synchronous, active high) restores register defaults and clears control state only.
// ----------------------------------------------------------------------------
// Line-scan track steering: top level
// Configuration registers, duty fraction precompute, and the scanner, frame
// queue and drive stage wired front to back.
// ----------------------------------------------------------------------------
module line_scan_track_steering (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lsts_pkg::PIX_W-1:0]        pixel_value,
  input  logic                              frame_end,
  input  logic [lsts_pkg::SPD_W-1:0]        speed_measure,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lsts_pkg::POS_W-1:0]        track_centre,
  output logic [1:0]                        steer_class,
  output logic                              servo_update,
  output logic [lsts_pkg::SERVO_W-1:0]      servo_duty,
  output logic [lsts_pkg::DUTY_W-1:0]       motor_a_duty,
  output logic [lsts_pkg::DUTY_W-1:0]       motor_b_duty,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsts_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lsts_pkg::*;

  logic [POS_W-1:0]  slope_threshold;
  logic [SPD_W-1:0]  speed_threshold;
  logic [POS_W-1:0]  band_left;
  logic [POS_W-1:0]  band_right;
  logic [DUTY_W-1:0] base_duty;
  logic [DUTY_W-1:0] fast_hi;
  logic [DUTY_W-1:0] fast_lo;
  logic [DUTY_W-1:0] slow_hi;
  logic [DUTY_W-1:0] slow_lo;

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  lsts_frame_t       frame;
  lsts_frame_t       head;
  lsts_drive_cfg_t   drive_cfg;

  logic [DUTY_W+16-1:0] nine_prod;
  logic [DUTY_W+16-1:0] seven_prod;
  logic [DUTY_W+8-1:0]  third_prod;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_threshold <= POS_W'(10);
      speed_threshold <= SPD_W'(13);
      band_left       <= POS_W'(55);
      band_right      <= POS_W'(77);
      base_duty       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLOPE_THR:  slope_threshold <= cfg_data[POS_W-1:0];
        CFG_SPEED_THR:  speed_threshold <= cfg_data[SPD_W-1:0];
        CFG_BAND_LEFT:  band_left       <= cfg_data[POS_W-1:0];
        CFG_BAND_RIGHT: band_right      <= cfg_data[POS_W-1:0];
        CFG_BASE_DUTY:  base_duty       <= cfg_data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the fast and braking fractions of the base duty
  assign nine_prod  = (DUTY_W+16)'(base_duty) * (DUTY_W+16)'(NINE_TENTHS);
  assign seven_prod = (DUTY_W+16)'(base_duty) * (DUTY_W+16)'(SEVEN_TENTHS);
  assign third_prod = (DUTY_W+8)'(base_duty) * (DUTY_W+8)'(THIRD_RECIP);

  always_ff @(posedge clk) begin
    fast_hi <= DUTY_W'(nine_prod >> TENTH_SHIFT);
    fast_lo <= DUTY_W'(seven_prod >> TENTH_SHIFT);
    slow_hi <= base_duty >> 1;
    slow_lo <= DUTY_W'(third_prod >> THIRD_SHIFT);
  end

  assign drive_cfg.speed_threshold = speed_threshold;
  assign drive_cfg.band_left       = band_left;
  assign drive_cfg.band_right      = band_right;
  assign drive_cfg.base_duty       = base_duty;
  assign drive_cfg.fast_hi         = fast_hi;
  assign drive_cfg.fast_lo         = fast_lo;
  assign drive_cfg.slow_hi         = slow_hi;
  assign drive_cfg.slow_lo         = slow_lo;

  lsts_scan u_scan (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pixel_value     (pixel_value),
    .frame_end       (frame_end),
    .speed_measure   (speed_measure),
    .slope_threshold (slope_threshold),
    .q_full          (q_full),
    .push            (push),
    .frame           (frame)
  );

  lsts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (frame),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  lsts_drive u_drive (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .cfg          (drive_cfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .track_centre (track_centre),
    .steer_class  (steer_class),
    .servo_update (servo_update),
    .servo_duty   (servo_duty),
    .motor_a_duty (motor_a_duty),
    .motor_b_duty (motor_b_duty)
  );

endmodule
